// ===== rtl/wkc_pkg.sv =====
// ----------------------------------------------------------------------------
// wkc_pkg
// Types and constants shared by the weighted k-nearest-neighbour classifier.
// ----------------------------------------------------------------------------
package wkc_pkg;

   localparam int MAX_TEMPLATES_DEF = 64;
   localparam int FEATURE_COUNT_DEF = 10;
   localparam int MAX_NEIGHBORS_DEF = 50;
   localparam int NUM_CLASSES_DEF   = 16;
   localparam int FEATURE_PORTS     = 10;

   localparam logic [5:0]  NEIGHBOR_RESET   = 6'd5;
   localparam logic [31:0] WEIGHT_NUMERATOR = 32'd65536000;
   localparam logic [31:0] SAT32            = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      MODE_CLASSIFY = 2'd0,
      MODE_ADD      = 2'd1,
      MODE_CLEAR    = 2'd2,
      MODE_NOP      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_NO_VOTE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT,
      CELL_CLEAR
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic [31:0]  distance;
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_MAC,
      ST_SQRT_START,
      ST_SQRT_WAIT,
      ST_INSERT,
      ST_VOTE_LOAD,
      ST_VOTE_DIV,
      ST_VOTE_ADD,
      ST_ARGMAX
   } state_type;

   typedef struct packed {
      cell_cmd_type cell_cmd;
      logic         feat_we;
      logic         lab_we;
      logic         sqrt_start;
      logic         div_start;
   } ctl_type;

endpackage

// ===== rtl/weighted_knn_classifier_top.sv =====
// ----------------------------------------------------------------------------
// weighted_knn_classifier_top
// Distance-weighted k-NN classifier with a sorted chain of neighbour cells.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  request  | start / busy           | req_mode, req_class_label, req_feature_*
//  response | rsp_valid (one cycle)  | rsp_result_label, rsp_status,
//           |                        | rsp_nearest_distance, rsp_stored_count
//  csr      | csr_write_enable       | csr_write_data (neighbour count)
//
// Clear, no-op, refused add and empty-store classify are answered straight from
// idle; an add first writes its features into the store. Classify time is set
// by the shared squarer, the 2-bit-per-cycle square root and the bit-serial
// weight divider. One transaction at a time; busy is high until the response
// strobe. Synchronous active-high reset empties the store and sets k to 5. The
// receiver cannot stall the response.
module weighted_knn_classifier_top #(
   parameter int MAX_TEMPLATES = wkc_pkg::MAX_TEMPLATES_DEF,
   parameter int FEATURE_COUNT = wkc_pkg::FEATURE_COUNT_DEF,
   parameter int MAX_NEIGHBORS = wkc_pkg::MAX_NEIGHBORS_DEF,
   parameter int NUM_CLASSES   = wkc_pkg::NUM_CLASSES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [3:0]         req_class_label,
   input  logic signed [31:0] req_feature_0,
   input  logic signed [31:0] req_feature_1,
   input  logic signed [31:0] req_feature_2,
   input  logic signed [31:0] req_feature_3,
   input  logic signed [31:0] req_feature_4,
   input  logic signed [31:0] req_feature_5,
   input  logic signed [31:0] req_feature_6,
   input  logic signed [31:0] req_feature_7,
   input  logic signed [31:0] req_feature_8,
   input  logic signed [31:0] req_feature_9,
   output logic               rsp_valid,
   output logic [3:0]         rsp_result_label,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_nearest_distance,
   output logic [6:0]         rsp_stored_count,
   input  logic               csr_write_enable,
   input  logic [5:0]         csr_write_data
);
   import wkc_pkg::*;

   localparam int IDX_W   = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;
   localparam int CNT_W   = $clog2(MAX_TEMPLATES + 1);
   localparam int FDEPTH  = MAX_TEMPLATES * FEATURE_COUNT;
   localparam int FADDR_W = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
   localparam int STEP_W  = $clog2(FEATURE_COUNT + 2);
   localparam int FSEL_W  = $clog2(FEATURE_PORTS);
   localparam int NB_W    = $clog2(MAX_NEIGHBORS + 1);
   localparam int CLS_W   = $clog2(NUM_CLASSES);
   localparam int ACC_W   = 66 + $clog2(FEATURE_COUNT + 1);

   state_type state_ff, state_in;
   ctl_type   ctl;

   logic [5:0]         k_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [31:0]        feat_ff [FEATURE_PORTS];
   logic [3:0]         label_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [CNT_W-1:0]   tmpl_ff;
   logic [FADDR_W-1:0] base_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [65:0]        prod_ff;
   logic [31:0]        dist_ff;
   logic [NB_W-1:0]    vote_cnt_ff;
   logic [NB_W-1:0]    filled_ff;
   logic [31:0]        votes_ff [NUM_CLASSES];
   logic [CLS_W-1:0]   cls_ff;
   logic [31:0]        top_ff;
   logic [CLS_W-1:0]   win_ff;
   logic [31:0]        nearest_ff;

   logic               rsp_valid_ff;
   logic [3:0]         rsp_label_ff;
   status_type         rsp_status_ff;
   logic [31:0]        rsp_dist_ff;
   logic [6:0]         rsp_count_ff;

   logic               accept;
   logic               full;
   logic               mac_last;
   logic               acc_sat;
   logic               tmpl_last;
   logic               vote_last;
   logic               cls_last;

   logic [FADDR_W-1:0] feat_wr_addr, feat_rd_addr;
   logic [31:0]        feat_wr_data, feat_rd_data;
   logic [3:0]         lab_rd_data;

   logic signed [32:0] diff;
   logic [32:0]        mag;

   logic               sqrt_done, div_done;
   logic [31:0]        sqrt_root, div_quo;
   logic [31:0]        weight, vote_sum;

   logic [NB_W-1:0]    filled_calc;

   cell_ctrl_type      cell_ctrl;
   logic               c_valid [MAX_NEIGHBORS];
   logic [31:0]        c_dist  [MAX_NEIGHBORS];
   logic [IDX_W-1:0]   c_idx   [MAX_NEIGHBORS];

   logic [31:0]        req_feat [FEATURE_PORTS];

   assign req_feat[0] = req_feature_0;
   assign req_feat[1] = req_feature_1;
   assign req_feat[2] = req_feature_2;
   assign req_feat[3] = req_feature_3;
   assign req_feat[4] = req_feature_4;
   assign req_feat[5] = req_feature_5;
   assign req_feat[6] = req_feature_6;
   assign req_feat[7] = req_feature_7;
   assign req_feat[8] = req_feature_8;
   assign req_feat[9] = req_feature_9;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign full      = (int'(count_ff) >= MAX_TEMPLATES);
   assign mac_last  = (int'(step_ff) == FEATURE_COUNT + 1);
   assign acc_sat   = (acc_ff[ACC_W-1:64] != '0);
   assign tmpl_last = (int'(tmpl_ff) + 1 == int'(count_ff));
   assign vote_last = (int'(vote_cnt_ff) + 1 == int'(filled_ff));
   assign cls_last  = (int'(cls_ff) == NUM_CLASSES - 1);

   // k clamped to 1..MAX_NEIGHBORS, then to the template count
   always_comb begin
      int kk;
      kk = int'(k_ff);
      if (kk < 1) begin
         kk = 1;
      end
      if (kk > MAX_NEIGHBORS) begin
         kk = MAX_NEIGHBORS;
      end
      if (kk > int'(count_ff)) begin
         kk = int'(count_ff);
      end
      filled_calc = NB_W'(kk);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (mode_type'(req_mode) == MODE_ADD && !full) begin
                  state_in = ST_ADD;
               end else if (mode_type'(req_mode) == MODE_CLASSIFY && count_ff != '0) begin
                  state_in = ST_MAC;
               end
            end
         end
         ST_ADD: begin
            if (int'(step_ff) == FEATURE_COUNT - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_MAC: begin
            if (mac_last) begin
               state_in = ST_SQRT_START;
            end
         end
         ST_SQRT_START: state_in = acc_sat ? ST_INSERT : ST_SQRT_WAIT;
         ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT:    state_in = tmpl_last ? ST_VOTE_LOAD : ST_MAC;
         ST_VOTE_LOAD: state_in = ST_VOTE_DIV;
         ST_VOTE_DIV: begin
            if (div_done) begin
               state_in = ST_VOTE_ADD;
            end
         end
         ST_VOTE_ADD:  state_in = vote_last ? ST_ARGMAX : ST_VOTE_LOAD;
         ST_ARGMAX: begin
            if (cls_last) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctl = '{cell_cmd: CELL_HOLD, feat_we: 1'b0, lab_we: 1'b0,
              sqrt_start: 1'b0, div_start: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            if (accept && mode_type'(req_mode) == MODE_CLASSIFY) begin
               ctl.cell_cmd = CELL_CLEAR;
            end
         end
         ST_ADD: begin
            ctl.feat_we = 1'b1;
            ctl.lab_we  = (step_ff == '0);
         end
         ST_SQRT_START: ctl.sqrt_start = !acc_sat;
         ST_INSERT:     ctl.cell_cmd   = CELL_INSERT;
         ST_VOTE_LOAD:  ctl.div_start  = 1'b1;
         ST_VOTE_ADD:   ctl.cell_cmd   = CELL_SHIFT;
         default: ;
      endcase
   end

   // template store
   assign feat_wr_addr = FADDR_W'(int'(count_ff) * FEATURE_COUNT + int'(step_ff));
   assign feat_wr_data = feat_ff[FSEL_W'(step_ff)];
   assign feat_rd_addr = FADDR_W'(int'(base_ff) + int'(step_ff));

   wkc_ram #(
      .WIDTH (32),
      .DEPTH (FDEPTH)
   ) u_feat_ram (
      .clock   (clock),
      .wr_en   (ctl.feat_we),
      .wr_addr (feat_wr_addr),
      .wr_data (feat_wr_data),
      .rd_addr (feat_rd_addr),
      .rd_data (feat_rd_data)
   );

   wkc_ram #(
      .WIDTH (4),
      .DEPTH (MAX_TEMPLATES)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (ctl.lab_we),
      .wr_addr (IDX_W'(count_ff)),
      .wr_data (label_ff),
      .rd_addr (c_idx[0]),
      .rd_data (lab_rd_data)
   );

   // absolute difference of one feature
   always_comb begin
      logic [31:0] fv;
      fv   = feat_ff[FSEL_W'(int'(step_ff) - 1)];
      diff = $signed({fv[31], fv}) - $signed({feat_rd_data[31], feat_rd_data});
      mag  = diff[32] ? 33'(-diff) : 33'(diff);
   end

   wkc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.sqrt_start),
      .radicand (acc_ff[63:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   wkc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend (WEIGHT_NUMERATOR),
      .divisor  (c_dist[0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign weight   = (dist_ff == '0) ? SAT32 : div_quo;
   assign vote_sum = 32'(votes_ff[CLS_W'(lab_rd_data)] + weight);

   // neighbour chain
   assign cell_ctrl.cmd      = ctl.cell_cmd;
   assign cell_ctrl.distance = dist_ff;

   for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
      logic             pv, nv;
      logic [31:0]      pd, nd;
      logic [IDX_W-1:0] pi, ni;
      if (g == 0) begin : g_head
         assign pv = 1'b1;
         assign pd = '0;
         assign pi = '0;
      end else begin : g_body
         assign pv = c_valid[g-1];
         assign pd = c_dist[g-1];
         assign pi = c_idx[g-1];
      end
      if (g == MAX_NEIGHBORS - 1) begin : g_tail
         assign nv = 1'b0;
         assign nd = '0;
         assign ni = '0;
      end else begin : g_mid
         assign nv = c_valid[g+1];
         assign nd = c_dist[g+1];
         assign ni = c_idx[g+1];
      end
      wkc_cell #(
         .IDX_W (IDX_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .new_idx    (IDX_W'(tmpl_ff)),
         .prev_valid (pv),
         .prev_dist  (pd),
         .prev_idx   (pi),
         .next_valid (nv),
         .next_dist  (nd),
         .next_idx   (ni),
         .valid      (c_valid[g]),
         .distance   (c_dist[g]),
         .idx        (c_idx[g])
      );
   end

   // datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= NEIGHBOR_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         if (csr_write_enable) begin
            k_ff <= csr_write_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  for (int i = 0; i < FEATURE_PORTS; i++) begin
                     feat_ff[i] <= req_feat[i];
                  end
                  label_ff    <= req_class_label;
                  step_ff     <= '0;
                  tmpl_ff     <= '0;
                  base_ff     <= '0;
                  acc_ff      <= '0;
                  filled_ff   <= filled_calc;
                  rsp_label_ff  <= '0;
                  rsp_status_ff <= STATUS_OK;
                  rsp_dist_ff   <= '0;
                  rsp_count_ff  <= 7'(count_ff);
                  case (mode_type'(req_mode))
                     MODE_ADD: begin
                        if (full) begin
                           rsp_status_ff <= STATUS_FULL;
                           rsp_valid_ff  <= 1'b1;
                        end
                     end
                     MODE_CLEAR: begin
                        count_ff     <= '0;
                        rsp_count_ff <= '0;
                        rsp_valid_ff <= 1'b1;
                     end
                     MODE_CLASSIFY: begin
                        if (count_ff == '0) begin
                           rsp_status_ff <= STATUS_EMPTY;
                           rsp_valid_ff  <= 1'b1;
                        end
                     end
                     default: rsp_valid_ff <= 1'b1;
                  endcase
               end
            end
            ST_ADD: begin
               step_ff <= step_ff + 1'b1;
               if (int'(step_ff) == FEATURE_COUNT - 1) begin
                  count_ff     <= count_ff + 1'b1;
                  rsp_count_ff <= 7'(count_ff + 1'b1);
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_MAC: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff != '0 && int'(step_ff) <= FEATURE_COUNT) begin
                  prod_ff <= 66'(mag) * 66'(mag);
               end
               if (int'(step_ff) >= 2) begin
                  acc_ff <= acc_ff + ACC_W'(prod_ff);
               end
            end
            ST_SQRT_START: begin
               if (acc_sat) begin
                  dist_ff <= SAT32;
               end
            end
            ST_SQRT_WAIT: begin
               if (sqrt_done) begin
                  dist_ff <= sqrt_root;
               end
            end
            ST_INSERT: begin
               tmpl_ff <= tmpl_ff + 1'b1;
               base_ff <= FADDR_W'(int'(base_ff) + FEATURE_COUNT);
               step_ff <= '0;
               acc_ff  <= '0;
               vote_cnt_ff <= '0;
               for (int i = 0; i < NUM_CLASSES; i++) begin
                  votes_ff[i] <= '0;
               end
            end
            ST_VOTE_LOAD: begin
               dist_ff <= c_dist[0];
               if (vote_cnt_ff == '0) begin
                  nearest_ff <= c_dist[0];
               end
            end
            ST_VOTE_ADD: begin
               vote_cnt_ff <= vote_cnt_ff + 1'b1;
               if (int'(lab_rd_data) < NUM_CLASSES) begin
                  votes_ff[CLS_W'(lab_rd_data)] <= (vote_sum < weight) ? SAT32 : vote_sum;
               end
               cls_ff <= '0;
               top_ff <= '0;
               win_ff <= '0;
            end
            ST_ARGMAX: begin
               cls_ff <= cls_ff + 1'b1;
               if (votes_ff[cls_ff] > top_ff) begin
                  top_ff <= votes_ff[cls_ff];
                  win_ff <= cls_ff;
               end
               if (cls_last) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_dist_ff  <= nearest_ff;
                  if (votes_ff[cls_ff] > top_ff) begin
                     rsp_status_ff <= STATUS_OK;
                     rsp_label_ff  <= 4'(cls_ff);
                  end else if (top_ff == '0) begin
                     rsp_status_ff <= STATUS_NO_VOTE;
                     rsp_label_ff  <= '0;
                  end else begin
                     rsp_status_ff <= STATUS_OK;
                     rsp_label_ff  <= 4'(win_ff);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_label     = rsp_label_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_nearest_distance = rsp_dist_ff;
   assign rsp_stored_count     = rsp_count_ff;

endmodule

// ===== rtl/wkc_ram.sv =====
// ----------------------------------------------------------------------------
// wkc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wkc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wkc_cell.sv =====
// ----------------------------------------------------------------------------
// wkc_cell
// One slot of the sorted nearest-neighbour chain (distance, template index).
// ----------------------------------------------------------------------------
module wkc_cell #(
   parameter int IDX_W = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wkc_pkg::cell_ctrl_type ctrl,
   input  logic [IDX_W-1:0]       new_idx,
   input  logic                   prev_valid,
   input  logic [31:0]            prev_dist,
   input  logic [IDX_W-1:0]       prev_idx,
   input  logic                   next_valid,
   input  logic [31:0]            next_dist,
   input  logic [IDX_W-1:0]       next_idx,
   output logic                   valid,
   output logic [31:0]            distance,
   output logic [IDX_W-1:0]       idx
);
   import wkc_pkg::*;

   logic             valid_ff, valid_in;
   logic [31:0]      dist_ff, dist_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_comb begin
      valid_in = valid_ff;
      dist_in  = dist_ff;
      idx_in   = idx_ff;
      case (ctrl.cmd)
         CELL_INSERT: begin
            // strict compare: an equal distance stays ahead (lower index)
            if (!valid_ff || ctrl.distance < dist_ff) begin
               if (prev_valid && prev_dist <= ctrl.distance) begin
                  valid_in = 1'b1;
                  dist_in  = ctrl.distance;
                  idx_in   = new_idx;
               end else begin
                  valid_in = prev_valid;
                  dist_in  = prev_dist;
                  idx_in   = prev_idx;
               end
            end
         end
         CELL_SHIFT: begin
            valid_in = next_valid;
            dist_in  = next_dist;
            idx_in   = next_idx;
         end
         CELL_CLEAR: valid_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      dist_ff <= dist_in;
      idx_ff  <= idx_in;
   end

   assign valid    = valid_ff;
   assign distance = dist_ff;
   assign idx      = idx_ff;

endmodule

// ===== rtl/wkc_isqrt.sv =====
// ----------------------------------------------------------------------------
// wkc_isqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module wkc_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] n_ff, n_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [34:0] rem_t, trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_t   = {rem_ff, n_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         n_in = {n_ff[61:0], 2'b00};
         if (rem_t >= trial) begin
            rem_in  = 33'(rem_t - trial);
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_t[32:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/wkc_div.sv =====
// ----------------------------------------------------------------------------
// wkc_div
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wkc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] rem_t;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      rem_t   = {rem_ff, quo_ff[31]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (rem_t >= {1'b0, dvs_ff}) begin
            rem_in = 32'(rem_t - {1'b0, dvs_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_t[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== test/tb_weighted_knn_classifier_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weighted_knn_classifier_top
// Drives add, clear, classify and no-op transactions into the k-NN classifier,
// predicts each response with a local model of the template store and the
// weighted vote, and checks every response field against it.
// ----------------------------------------------------------------------------
module tb_weighted_knn_classifier_top;
   import wkc_pkg::*;

   localparam int NTMPL  = 64;
   localparam int NFEAT  = 10;
   localparam int NCLASS = 16;
   localparam longint CYCLE_LIMIT = 64'd40_000_000;

   typedef struct packed {
      logic [3:0]  label;
      logic [1:0]  status;
      logic [31:0] distance;
      logic [6:0]  count;
   } answer_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_mode = '0;
   logic [3:0] req_class_label = '0;
   logic signed [31:0] req_feature [NFEAT];
   logic rsp_valid;
   logic [3:0] rsp_result_label;
   logic [1:0] rsp_status;
   logic [31:0] rsp_nearest_distance;
   logic [6:0] rsp_stored_count;
   logic csr_write_enable = 0;
   logic [5:0] csr_write_data = '0;

   logic [31:0] store_feat [NTMPL][NFEAT];
   logic [3:0]  store_label [NTMPL];
   int          store_count;
   logic [5:0]  k_setting;
   answer_type  pending_answers [$];
   int          errors;
   longint      cycles;
   bit          no_idle;

   initial for (int i = 0; i < NFEAT; i++) req_feature[i] = '0;

   weighted_knn_classifier_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_class_label(req_class_label),
      .req_feature_0(req_feature[0]), .req_feature_1(req_feature[1]),
      .req_feature_2(req_feature[2]), .req_feature_3(req_feature[3]),
      .req_feature_4(req_feature[4]), .req_feature_5(req_feature[5]),
      .req_feature_6(req_feature[6]), .req_feature_7(req_feature[7]),
      .req_feature_8(req_feature[8]), .req_feature_9(req_feature[9]),
      .rsp_valid(rsp_valid), .rsp_result_label(rsp_result_label),
      .rsp_status(rsp_status), .rsp_nearest_distance(rsp_nearest_distance),
      .rsp_stored_count(rsp_stored_count),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] int_sqrt(logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r[31:0];
   endfunction

   function automatic logic [31:0] template_distance(logic signed [31:0] f [NFEAT], int t);
      logic [67:0] sum;
      logic signed [32:0] d;
      logic [32:0] m;
      sum = 0;
      for (int i = 0; i < NFEAT; i++) begin
         d = 33'(f[i]) - 33'($signed(store_feat[t][i]));
         m = d < 0 ? 33'(-d) : 33'(d);
         sum = sum + 68'(m) * 68'(m);
      end
      if (sum[67:64] != 0) return SAT32;
      return int_sqrt(sum[63:0]);
   endfunction

   // advances the store and returns the answer to one transaction
   function automatic answer_type predict_answer(logic [1:0] mode, logic [3:0] lab,
                                                 logic signed [31:0] f [NFEAT]);
      answer_type a;
      int k;
      int filled;
      int pos;
      logic [31:0] bd [50];
      int bi [50];
      logic [31:0] votes [NCLASS];
      logic [31:0] d;
      logic [31:0] w;
      logic [32:0] s;
      logic [31:0] top;
      int win;
      a = '{label: '0, status: STATUS_OK, distance: '0, count: '0};
      case (mode)
         MODE_ADD: begin
            if (store_count >= NTMPL) a.status = STATUS_FULL;
            else begin
               for (int i = 0; i < NFEAT; i++) store_feat[store_count][i] = f[i];
               store_label[store_count] = lab;
               store_count++;
            end
         end
         MODE_CLEAR: store_count = 0;
         MODE_CLASSIFY: begin
            if (store_count == 0) a.status = STATUS_EMPTY;
            else begin
               k = k_setting;
               if (k < 1) k = 1;
               if (k > 50) k = 50;
               if (k > store_count) k = store_count;
               filled = 0;
               for (int i = 0; i < store_count; i++) begin
                  d = template_distance(f, i);
                  if (!(filled == k && d >= bd[k-1])) begin
                     pos = filled < k ? filled : k - 1;
                     while (pos > 0 && bd[pos-1] > d) begin
                        bd[pos] = bd[pos-1];
                        bi[pos] = bi[pos-1];
                        pos--;
                     end
                     bd[pos] = d;
                     bi[pos] = i;
                     if (filled < k) filled++;
                  end
               end
               for (int c = 0; c < NCLASS; c++) votes[c] = 0;
               for (int j = 0; j < filled; j++) begin
                  w = bd[j] == 0 ? SAT32 : WEIGHT_NUMERATOR / bd[j];
                  s = 33'(votes[store_label[bi[j]]]) + 33'(w);
                  votes[store_label[bi[j]]] = s[32] ? SAT32 : s[31:0];
               end
               top = 0;
               win = 0;
               for (int c = 0; c < NCLASS; c++)
                  if (votes[c] > top) begin
                     top = votes[c];
                     win = c;
                  end
               a.distance = bd[0];
               if (top == 0) a.status = STATUS_NO_VOTE;
               else a.label = 4'(win);
            end
         end
         default: ;
      endcase
      a.count = 7'(store_count);
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $display("%0t unexpected response: label %0d status %0d dist %h count %0d",
                     $time, rsp_result_label, rsp_status, rsp_nearest_distance,
                     rsp_stored_count);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_result_label !== want.label) begin
               $display("%0t label: expected %0d actual %0d", $time, want.label,
                        rsp_result_label);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t status: expected %0d actual %0d", $time, want.status,
                        rsp_status);
               errors++;
            end
            if (rsp_nearest_distance !== want.distance) begin
               $display("%0t distance: expected %h actual %h", $time, want.distance,
                        rsp_nearest_distance);
               errors++;
            end
            if (rsp_stored_count !== want.count) begin
               $display("%0t count: expected %0d actual %0d", $time, want.count,
                        rsp_stored_count);
               errors++;
            end
         end
      end
   end

   // start drops only when the sender actually pauses
   task automatic idle_gap();
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_transaction(logic [1:0] mode, logic [3:0] lab,
                                   logic signed [31:0] f [NFEAT]);
      idle_gap();
      start <= 1;
      req_mode <= mode;
      req_class_label <= lab;
      for (int i = 0; i < NFEAT; i++) req_feature[i] <= f[i];
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_answers.push_back(predict_answer(mode, lab, f));
   endtask

   task automatic drain();
      start <= 0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_k(logic [5:0] v);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      k_setting = v;
   endtask

   // clustered values so distances stay meaningful, with occasional extremes
   function automatic logic [31:0] random_feature(int centre);
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         default: return 32'(centre * 32'h0001_0000 + $urandom_range(0, 32'h3_0000) -
                             32'h1_8000);
      endcase
   endfunction

   task automatic send_random(logic [1:0] mode, logic [3:0] lab, int centre);
      logic signed [31:0] f [NFEAT];
      for (int i = 0; i < NFEAT; i++) f[i] = random_feature(centre);
      send_transaction(mode, lab, f);
   endtask

   task automatic test_directed();
      logic signed [31:0] f [NFEAT];
      for (int i = 0; i < NFEAT; i++) f[i] = 0;
      send_transaction(MODE_CLASSIFY, 0, f);
      send_transaction(MODE_NOP, 4'hF, f);
      send_transaction(MODE_ADD, 4'd3, f);
      send_transaction(MODE_CLASSIFY, 0, f);
      for (int i = 0; i < NFEAT; i++) f[i] = 32'h7FFF_FFFF;
      send_transaction(MODE_ADD, 4'hF, f);
      for (int i = 0; i < NFEAT; i++) f[i] = 32'h8000_0000;
      send_transaction(MODE_CLASSIFY, 0, f);
      send_transaction(MODE_ADD, 4'd7, f);
      send_transaction(MODE_CLASSIFY, 0, f);
      for (int i = 0; i < NFEAT; i++) f[i] = 32'h0001_0000;
      send_transaction(MODE_ADD, 4'd3, f);
      send_transaction(MODE_CLASSIFY, 0, f);
      for (int i = 0; i < NFEAT; i++) f[i] = 32'h0400_0000;
      send_transaction(MODE_CLASSIFY, 0, f);
      send_transaction(MODE_CLEAR, 0, f);
      send_transaction(MODE_CLASSIFY, 0, f);
   endtask

   task automatic test_store_full();
      for (int i = 0; i < NTMPL + 3; i++) send_random(MODE_ADD, 4'($urandom()), i % 4);
      send_random(MODE_CLASSIFY, 0, 1);
      send_random(MODE_CLASSIFY, 0, 2);
      send_random(MODE_CLEAR, 0, 0);
   endtask

   task automatic test_random(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 2) send_random(MODE_CLEAR, 0, 0);
         else if (r < 4) send_random(MODE_NOP, 4'($urandom()), 0);
         else if (r < 45 || store_count < 3)
            send_random(MODE_ADD, 4'($urandom_range(0, 3)), $urandom_range(0, 3));
         else send_random(MODE_CLASSIFY, 0, $urandom_range(0, 3));
      end
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      no_idle = 0;
      store_count = 0;
      k_setting = NEIGHBOR_RESET;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_store_full();
      write_k(6'd0);
      test_random(120);
      write_k(6'd1);
      test_random(120);
      write_k(6'd63);
      test_random(120);
      write_k(6'd50);
      test_random(120);
      write_k(6'($urandom_range(2, 20)));
      test_random(120);
      no_idle = 1;
      test_random(60);
      drain();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/wkc_pkg.sv
rtl/wkc_ram.sv
rtl/wkc_cell.sv
rtl/wkc_isqrt.sv
rtl/wkc_div.sv
rtl/weighted_knn_classifier_top.sv
test/tb_weighted_knn_classifier_top.sv
